// File: design/rrfd_pkg.sv
package rrfd_pkg;

  localparam int unsigned PATH_CAPTURE_MAX = 256;
  localparam int unsigned PATH_LEN_W       = 9;
  localparam int unsigned HDR_BYTES        = 24;
  localparam int unsigned HDR_IDX_W        = 5;

  localparam logic [HDR_IDX_W-1:0] REQ_HDR_LEN  = 5'd24;
  localparam logic [HDR_IDX_W-1:0] RESP_HDR_LEN = 5'd8;

  localparam logic [15:0] OP_BASE     = 16'd3000;
  localparam logic [15:0] OP_LAST     = 16'd3031;
  localparam logic [15:0] OP_CHKPOINT = 16'd3012;
  localparam logic [15:0] OP_WRITE    = 16'd3019;
  localparam logic [15:0] OP_PGWRITE  = 16'd3026;
  localparam logic [15:0] OP_WRITEV   = 16'd3031;
  localparam logic [15:0] ST_ERROR    = 16'd4003;
  localparam logic [7:0]  CKP_XEQ     = 8'd4;

  localparam logic [31:0] MAX_WRITE_BODY  = 32'd16777216;
  localparam logic [31:0] MAX_WRITEV_LIST = 32'd16384;
  localparam logic [4:0]  CKP_HDR_LEN     = 5'd24;
  localparam logic [31:0] ERR_BODY_LEN    = 32'd4;

  // configuration register indexes
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_PREAMBLE  = 2'd1;
  localparam logic [1:0] REG_PATH_MASK = 2'd2;

  // result kinds
  localparam logic KIND_PATH   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic                  result_kind;
    logic [7:0]            path_byte;
    logic [15:0]           stream_id;
    logic [15:0]           frame_code;
    logic [31:0]           payload_length;
    logic [31:0]           error_number;
    logic [PATH_LEN_W-1:0] path_length;
  } res_t;

endpackage

// File: design/rrfd_if.sv
interface rrfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rrfd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  path_byte;
  logic [15:0] stream_id;
  logic [15:0] frame_code;
  logic [31:0] payload_length;
  logic [31:0] error_number;
  logic [8:0]  path_length;
  modport source (output valid, output result_kind, output path_byte, output stream_id,
                  output frame_code, output payload_length, output error_number,
                  output path_length, input ready);
  modport sink   (input valid, input result_kind, input path_byte, input stream_id,
                  input frame_code, input payload_length, input error_number,
                  input path_length, output ready);
endinterface

interface rrfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/rrfd_out_fifo.sv
module rrfd_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_n_i,
  input  rrfd_pkg::res_t res0_i,
  input  rrfd_pkg::res_t res1_i,
  output logic           room_o,
  output logic           valid_o,
  output rrfd_pkg::res_t data_o,
  input  logic           pop_i
);
  import rrfd_pkg::*;

  res_t       mem_q [4];
  logic [1:0] head_q, tail_q;
  logic [2:0] count_q;
  logic       do_pop;

  assign valid_o = (count_q != 3'd0);
  assign data_o  = mem_q[head_q];
  assign room_o  = (count_q <= 3'd2);
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[tail_q] <= res0_i;
    if (push_n_i == 2'd2) mem_q[tail_q + 2'd1] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + push_n_i;
      head_q  <= head_q + {1'b0, do_pop};
      count_q <= count_q + {1'b0, push_n_i} - {2'b0, do_pop};
    end
  end
endmodule

// File: design/request_response_frame_decoder.sv
// Frame decoder for a relayed request/response byte stream.
// in_ch carries one stream byte per transaction; out_ch carries result
// transactions: passed path bytes (kind 0) and one frame record (kind 1) per frame.
// cfg_ch writes the direction, preamble length and path opcode mask; it is always
// ready. Writing direction or preamble length restarts the decoder; writing the
// mask takes effect from the next header.
// Each byte is decoded in the cycle it is taken: its results enter a four-entry
// output queue at that edge and reach out_ch from its head, behind any earlier
// results. One byte is taken every cycle while the queue has room. A byte
// yields at most two results (a path byte followed by the record).
// When out_ch stalls the queue fills; in_ch ready drops once fewer than two
// entries are free and rises again as results drain.
// Reset empties the queue, clears decode state except the header bytes and loads
// direction 0, preamble length 20, an empty mask: the first 20 bytes are swallowed.
module request_response_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrfd_in_if.sink    in_ch,
  rrfd_out_if.source out_ch,
  rrfd_cfg_if.sink   cfg_ch
);
  import rrfd_pkg::*;

  // configuration
  logic        dir_q;
  logic [7:0]  pre_len_q;
  logic [31:0] mask_q;

  // decode state
  logic [7:0]            pre_q, pre_d;
  logic [7:0]            hdr_q [HDR_BYTES];
  logic [7:0]            hdr_d [HDR_BYTES];
  logic [HDR_IDX_W-1:0]  hc_q, hc_d;
  logic                  inp_q, inp_d;
  logic [63:0]           pl_q, pl_d;
  logic                  rs_q, rs_d;
  logic [PATH_LEN_W-1:0] ct_q, ct_d, cc_q, cc_d;
  logic [31:0]           ea_q, ea_d;
  logic                  wv_q, wv_d;
  logic [3:0]            dc_q, dc_d;
  logic [31:0]           sla_q, sla_d;
  logic [63:0]           tt_q, tt_d;
  logic                  ck_q, ck_d;
  logic [4:0]            kc_q, kc_d;
  logic [15:0]           eid_q, eid_d;
  logic [31:0]           el_q, el_d;

  // per-byte working values
  logic        in_fire, cfg_fire, restart;
  logic [7:0]  b;
  logic [15:0] code;
  logic [15:0] op_off;
  logic [31:0] flen;
  logic        emit_path, emit_rec, extended, trail_skip;
  res_t        rec, pres, res0, res1;
  logic [1:0]  push_n;
  logic        room;
  res_t        out_data;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign restart  = cfg_fire && (cfg_ch.index == REG_DIRECTION ||
                                 cfg_ch.index == REG_PREAMBLE);
  assign b        = in_ch.data_byte;
  assign in_ch.ready  = room;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    pre_d = pre_q;  hdr_d = hdr_q;  hc_d = hc_q;  inp_d = inp_q;  pl_d = pl_q;
    rs_d = rs_q;    ct_d = ct_q;    cc_d = cc_q;  ea_d = ea_q;    wv_d = wv_q;
    dc_d = dc_q;    sla_d = sla_q;  tt_d = tt_q;  ck_d = ck_q;    kc_d = kc_q;
    eid_d = eid_q;  el_d = el_q;
    emit_path = 1'b0;  emit_rec = 1'b0;  extended = 1'b0;  trail_skip = 1'b0;

    if (in_fire && pre_q != 8'd0) begin
      pre_d = pre_q - 8'd1;
    end else if (in_fire && !inp_q) begin
      if (hc_q < REQ_HDR_LEN) hdr_d[hc_q] = b;
      hc_d = hc_q + 5'd1;
    end

    // header view (includes the byte just taken)
    code   = {hdr_d[2], hdr_d[3]};
    flen   = dir_q ? {hdr_d[4], hdr_d[5], hdr_d[6], hdr_d[7]}
                   : {hdr_d[20], hdr_d[21], hdr_d[22], hdr_d[23]};
    op_off = code - OP_BASE;

    if (in_fire && pre_q == 8'd0 && !inp_q &&
        hc_d >= (dir_q ? RESP_HDR_LEN : REQ_HDR_LEN)) begin
      // header complete
      inp_d = 1'b1;  pl_d = {32'd0, flen};  rs_d = 1'b0;
      cc_d = '0;  ct_d = '0;  ea_d = '0;
      wv_d = !dir_q && code == OP_WRITEV && flen != 32'd0 && flen[3:0] == 4'd0;
      dc_d = '0;  sla_d = '0;  tt_d = '0;
      ck_d = !dir_q && code == OP_CHKPOINT && hdr_d[19] == CKP_XEQ &&
             flen == 32'd24;
      kc_d = '0;
      if (!dir_q && flen != 32'd0 && code >= OP_BASE && code <= OP_LAST &&
          mask_q[op_off[4:0]])
        ct_d = (flen < PATH_CAPTURE_MAX) ? flen[PATH_LEN_W-1:0]
                                         : PATH_LEN_W'(PATH_CAPTURE_MAX);
      if (dir_q && code == ST_ERROR && flen != 32'd0)
        ct_d = (flen < ERR_BODY_LEN) ? flen[PATH_LEN_W-1:0]
                                     : ERR_BODY_LEN[PATH_LEN_W-1:0];
      if (ct_d == '0) begin
        emit_rec = 1'b1;
        rs_d     = 1'b1;
        if (flen == 32'd0) begin
          inp_d = 1'b0;
          hc_d  = '0;
        end
      end
    end else if (in_fire && pre_q == 8'd0 && inp_q) begin
      // payload byte
      if (cc_q < ct_q) begin
        if (!dir_q) emit_path = 1'b1;
        else        ea_d = {ea_q[23:0], b};
        cc_d = cc_q + 1'b1;
      end
      if (ck_q && kc_q < CKP_HDR_LEN) begin
        if (kc_q == 5'd2 || kc_q == 5'd3) eid_d = {eid_q[7:0], b};
        if (kc_q >= 5'd20) el_d = {el_q[23:0], b};
        kc_d = kc_q + 5'd1;
      end
      if (wv_q) begin
        if (dc_q >= 4'd4 && dc_q <= 4'd7) sla_d = {sla_q[23:0], b};
        if (dc_q == 4'd15) begin
          tt_d = tt_q + {32'd0, sla_d};
          dc_d = '0;
        end else begin
          dc_d = dc_q + 4'd1;
        end
      end
      pl_d = pl_q - 64'd1;
      if (!rs_q && cc_d >= ct_q) begin
        emit_rec = 1'b1;
        rs_d     = 1'b1;
      end
      if (pl_d == 64'd0) begin
        // frame end: checkpoint extension, then writev trailing data
        if (ck_q) begin
          ck_d = 1'b0;
          if (el_d != 32'd0 && kc_d == CKP_HDR_LEN) begin
            if ((eid_d == OP_WRITE || eid_d == OP_PGWRITE) &&
                el_d <= MAX_WRITE_BODY) begin
              pl_d = {32'd0, el_d};
              extended = 1'b1;
            end else if (eid_d == OP_WRITEV && el_d[3:0] == 4'd0 &&
                         el_d <= MAX_WRITEV_LIST) begin
              pl_d = {32'd0, el_d};
              wv_d = 1'b1;
              dc_d = '0;
              tt_d = '0;
              extended = 1'b1;
            end
          end
        end
        if (!extended) begin
          if (wv_d) begin
            wv_d = 1'b0;
            if (tt_d != 64'd0) begin
              pl_d = tt_d;
              trail_skip = 1'b1;
            end
          end
          if (!trail_skip) begin
            if (!rs_d) begin
              emit_rec = 1'b1;
              rs_d     = 1'b1;
            end
            inp_d = 1'b0;
            hc_d  = '0;
          end
        end
      end
    end

    rec.result_kind    = KIND_RECORD;
    rec.path_byte      = '0;
    rec.stream_id      = {hdr_d[0], hdr_d[1]};
    rec.frame_code     = code;
    rec.payload_length = flen;
    rec.error_number   = (dir_q && cc_d >= ERR_BODY_LEN[PATH_LEN_W-1:0]) ? ea_d : '0;
    rec.path_length    = dir_q ? '0 : cc_d;

    pres = '0;
    pres.result_kind = KIND_PATH;
    pres.path_byte   = b;

    res0   = emit_path ? pres : rec;
    res1   = rec;
    push_n = {1'b0, emit_path} + {1'b0, emit_rec};
  end

  // header bytes are plain data registers with no reset
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;  pre_len_q <= 8'd20;  mask_q <= '0;
      pre_q <= 8'd20; hc_q <= '0;  inp_q <= 1'b0;  pl_q <= '0;  rs_q <= 1'b0;
      ct_q <= '0;  cc_q <= '0;  ea_q <= '0;  wv_q <= 1'b0;  dc_q <= '0;
      sla_q <= '0; tt_q <= '0;  ck_q <= 1'b0;  kc_q <= '0;  eid_q <= '0;
      el_q <= '0;
    end else if (restart) begin
      // restart decoding with the new direction or preamble
      if (cfg_ch.index == REG_DIRECTION) begin
        dir_q <= cfg_ch.data[0];
        pre_q <= cfg_ch.data[0] ? 8'd0 : pre_len_q;
      end else begin
        pre_len_q <= cfg_ch.data[7:0];
        pre_q     <= dir_q ? 8'd0 : cfg_ch.data[7:0];
      end
      hc_q <= '0;  inp_q <= 1'b0;  pl_q <= '0;  rs_q <= 1'b0;
      ct_q <= '0;  cc_q <= '0;  ea_q <= '0;  wv_q <= 1'b0;  dc_q <= '0;
      sla_q <= '0; tt_q <= '0;  ck_q <= 1'b0;  kc_q <= '0;  eid_q <= '0;
      el_q <= '0;
    end else begin
      if (cfg_fire && cfg_ch.index == REG_PATH_MASK) mask_q <= cfg_ch.data;
      pre_q <= pre_d;  hc_q <= hc_d;  inp_q <= inp_d;  pl_q <= pl_d;  rs_q <= rs_d;
      ct_q <= ct_d;  cc_q <= cc_d;  ea_q <= ea_d;  wv_q <= wv_d;  dc_q <= dc_d;
      sla_q <= sla_d;  tt_q <= tt_d;  ck_q <= ck_d;  kc_q <= kc_d;
      eid_q <= eid_d;  el_q <= el_d;
    end
  end

  rrfd_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .room_o   (room),
    .valid_o  (out_ch.valid),
    .data_o   (out_data),
    .pop_i    (out_ch.ready)
  );

  assign out_ch.result_kind    = out_data.result_kind;
  assign out_ch.path_byte      = out_data.path_byte;
  assign out_ch.stream_id      = out_data.stream_id;
  assign out_ch.frame_code     = out_data.frame_code;
  assign out_ch.payload_length = out_data.payload_length;
  assign out_ch.error_number   = out_data.error_number;
  assign out_ch.path_length    = out_data.path_length;
endmodule
